@@ sv/rgbw_pkg.sv @@
// Shared types, codes and constants of the RGBW drive controller.
// Also holds the elaboration-time builder of the color temperature table.
// No dependencies.
`default_nettype none

package rgbw_pkg;

    // request codes
    localparam logic [2:0] REQ_POWER  = 3'd0;
    localparam logic [2:0] REQ_BRIGHT = 3'd1;
    localparam logic [2:0] REQ_RGB    = 3'd2;
    localparam logic [2:0] REQ_WHITE  = 3'd3;
    localparam logic [2:0] REQ_CT     = 3'd4;
    localparam logic [2:0] REQ_EFFECT = 3'd5;
    localparam logic [2:0] REQ_TICK   = 3'd6;

    // register indexes on the APB port
    localparam int          APB_AW        = 4;
    localparam logic [1:0]  REG_MIRED_MIN = 2'd0;
    localparam logic [1:0]  REG_MIRED_MAX = 2'd1;
    localparam logic [1:0]  REG_RB_PERIOD = 2'd2;

    localparam logic [9:0]  MIRED_MIN_RST = 10'd153;
    localparam logic [9:0]  MIRED_MAX_RST = 10'd500;
    localparam logic [31:0] RB_PERIOD_RST = 32'd10;

    // rainbow hue segments
    localparam logic [7:0] HUE_SEG1 = 8'd85;
    localparam logic [7:0] HUE_SEG2 = 8'd170;

    typedef struct packed {
        logic [2:0] req_type;
        logic       power_on;
        logic [7:0] level;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [9:0] mired_in;
        logic       effect_code;
    } t_req;

    typedef struct packed {
        logic       accepted;
        logic [7:0] duty_red;
        logic [7:0] duty_green;
        logic [7:0] duty_blue;
        logic [7:0] duty_white;
        logic       power_now;
        logic [7:0] brightness_now;
        logic [7:0] red_now;
        logic [7:0] green_now;
        logic [7:0] blue_now;
        logic [7:0] white_now;
        logic [9:0] mired_now;
    } t_rsp;

    typedef struct packed {
        logic [9:0]  mired_min;
        logic [9:0]  mired_max;
        logic [31:0] rainbow_period;
    } t_cfg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // ---- table builder constants (Q30 fixed point, coefficients x1e7, exponents x1e10)
    localparam int          Q          = 30;
    localparam logic [63:0] Q_ONE      = 64'd1 << Q;
    localparam logic [63:0] E7         = 64'd10000000;
    localparam logic [63:0] E10        = 64'd10000000000;
    localparam logic [63:0] MEGA       = 64'd1000000;
    localparam logic [63:0] KELVIN_MIN = 64'd1000;
    localparam logic [63:0] KELVIN_MAX = 64'd40000;
    localparam logic [63:0] KELVIN_DIV = 64'd100;
    localparam logic [63:0] CT_SPLIT   = 64'd66;
    localparam logic [63:0] CT_OFFSET  = 64'd60;
    localparam logic [63:0] BLU_ZERO   = 64'd19;
    localparam logic [63:0] BLU_OFFSET = 64'd10;
    localparam logic [63:0] RED_COEF   = 64'd3296987274;
    localparam logic [63:0] RED_EXPO   = 64'd1332047592;
    localparam logic [63:0] GRN_LOG_A  = 64'd994708025;
    localparam logic [63:0] GRN_LOG_B  = 64'd1611195681;
    localparam logic [63:0] GRN_COEF   = 64'd2881221695;
    localparam logic [63:0] GRN_EXPO   = 64'd755148492;
    localparam logic [63:0] BLU_LOG_A  = 64'd1385177312;
    localparam logic [63:0] BLU_LOG_B  = 64'd3050447927;

    // unsigned 64-bit quotient, restoring shift-subtract
    function automatic logic [63:0] udiv64(input logic [63:0] a,
                                           input logic [63:0] b);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], a[i]};
            if (rem >= 65'(b)) begin
                rem  = rem - 65'(b);
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // 2*atanh(num over den) in Q30; series terms die out to zero and then stay there
    function automatic logic [63:0] atanh2_q30(input logic [63:0] num,
                                               input logic [63:0] den);
        logic [63:0] z;
        logic [63:0] zz;
        logic [63:0] s;
        logic [63:0] p;
        z  = udiv64(num << Q, den);
        zz = (z * z) >> Q;
        s  = z;
        p  = z;
        for (int n = 3; n <= 61; n += 2) begin
            p = (p * zz) >> Q;
            s = s + p / 64'(n);
        end
        return s << 1;
    endfunction

    function automatic logic [63:0] ln_q30(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] base;
        int          k;
        x = (x_in < 64'd1) ? 64'd1 : x_in;
        k = 0;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) k = i;
        end
        base = 64'd1 << k;
        return 64'(k) * atanh2_q30(64'd1, 64'd3) + atanh2_q30(x - base, x + base);
    endfunction

    function automatic logic [63:0] exp_neg_q30(input logic [63:0] t_in);
        logic [63:0] t;
        logic [63:0] acc;
        logic [63:0] term;
        t    = (t_in >= Q_ONE) ? Q_ONE - 64'd1 : t_in;
        acc  = Q_ONE;
        term = Q_ONE;
        for (int i = 1; i <= 24; i++) begin
            term = ((term * t) >> Q) / 64'(i);
            if ((i & 1) == 1) acc = (term > acc) ? 64'd0 : acc - term;
            else              acc = acc + term;
        end
        return acc;
    endfunction

    function automatic logic [7:0] sat8(input logic [63:0] v);
        return (v > 64'd255) ? 8'd255 : v[7:0];
    endfunction

    function automatic logic [7:0] pow_term(input logic [63:0] x,
                                            input logic [63:0] coef,
                                            input logic [63:0] expo);
        logic [63:0] t;
        logic [63:0] prod;
        t    = (expo * ln_q30(x)) / E10;
        prod = coef * exp_neg_q30(t);
        return sat8((prod >> Q) / E7);
    endfunction

    function automatic logic [7:0] log_term(input logic [63:0] x,
                                            input logic [63:0] a,
                                            input logic [63:0] b);
        logic [63:0] p;
        logic [63:0] bq;
        p  = a * ln_q30(x);
        bq = b << Q;
        if (p <= bq) return 8'd0;
        return sat8(((p - bq) >> Q) / E7);
    endfunction

    // one table entry: RGB of a color temperature given in mired
    function automatic t_rgb ct_entry(input int unsigned m);
        logic [63:0] kelvin;
        logic [63:0] k;
        t_rgb        e;
        kelvin = (m == 0) ? KELVIN_MAX : MEGA / 64'(m);
        if (kelvin < KELVIN_MIN) kelvin = KELVIN_MIN;
        if (kelvin > KELVIN_MAX) kelvin = KELVIN_MAX;
        k = kelvin / KELVIN_DIV;
        e.red   = (k <= CT_SPLIT) ? 8'd255
                                  : pow_term(k - CT_OFFSET, RED_COEF, RED_EXPO);
        e.green = (k <= CT_SPLIT) ? log_term(k, GRN_LOG_A, GRN_LOG_B)
                                  : pow_term(k - CT_OFFSET, GRN_COEF, GRN_EXPO);
        if (k >= CT_SPLIT)      e.blue = 8'd255;
        else if (k <= BLU_ZERO) e.blue = 8'd0;
        else                    e.blue = log_term(k - BLU_OFFSET, BLU_LOG_A, BLU_LOG_B);
        return e;
    endfunction

endpackage

`default_nettype wire

@@ sv/rgbw_ct_rom.sv @@
// Color temperature table: mired -> 8-bit RGB, with registered read.
// Contents are built at elaboration from rgbw_pkg::ct_entry.
`default_nettype none

module rgbw_ct_rom
    import rgbw_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output      t_rgb                     o_rd_data
);

    t_rgb rom_word [DEPTH];
    t_rgb r_rd_data;

    for (genvar g = 0; g < DEPTH; g++) begin : g_entry
        localparam t_rgb ENTRY = ct_entry(g);
        assign rom_word[g] = ENTRY;
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= rom_word[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ sv/rgbw_dim.sv @@
// Brightness scaling of one color channel: color*brightness/255, truncated.
// Uses no package items.
`default_nettype none

module rgbw_dim (
    input  wire logic [7:0] i_color,
    input  wire logic [7:0] i_bright,
    output      logic [7:0] o_duty
);

    logic [15:0] prod;
    logic [16:0] sum;

    // exact x/255 for x < 65535: (x + (x >> 8) + 1) >> 8
    assign prod   = i_color * i_bright;
    assign sum    = 17'(prod) + 17'(prod[15:8]) + 17'd1;
    assign o_duty = sum[15:8];

endmodule

`default_nettype wire

@@ sv/rgbw_apb_regs.sv @@
// APB register file: mired limits and rainbow period.
// Depends on rgbw_pkg for register indexes, reset values and t_cfg.
`default_nettype none

module rgbw_apb_regs
    import rgbw_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output      logic [31:0]       prdata,
    output      logic              pready,
    output      t_cfg              o_cfg
);

    t_cfg r_cfg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mired_min      <= MIRED_MIN_RST;
            r_cfg.mired_max      <= MIRED_MAX_RST;
            r_cfg.rainbow_period <= RB_PERIOD_RST;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_MIRED_MIN: r_cfg.mired_min      <= pwdata[9:0];
                REG_MIRED_MAX: r_cfg.mired_max      <= pwdata[9:0];
                REG_RB_PERIOD: r_cfg.rainbow_period <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MIRED_MIN: prdata = 32'(r_cfg.mired_min);
            REG_MIRED_MAX: prdata = 32'(r_cfg.mired_max);
            REG_RB_PERIOD: prdata = r_cfg.rainbow_period;
            default:       prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ sv/rgbw_led_drive_controller.sv @@
// Top level of the RGBW drive controller: input register, command logic, result register.
// Depends on rgbw_pkg, rgbw_ct_rom, rgbw_dim and rgbw_apb_regs.
`default_nettype none

// One command or tick per cycle, one result per item. An accepted transaction is
// captured in the input register together with its color temperature table read
// (registered ROM port); once the result register is free or being taken, it is evaluated
// against the stored settings, updates them and loads the result register.
// o_out_valid rises when the result register is loaded. Throughput is one transaction
// per cycle while the result side takes one per cycle, and a stalled result side
// fills both registers and then holds o_in_ready low.
// The single-pass path is ROM data -> 8x8 multiply -> result register. The table
// holds MIRED_TABLE_DEPTH entries, computed at elaboration; mired values past its
// end read the last entry.
// Registers (APB, 4-byte stride): 0 mired_min, 1 mired_max, 2 rainbow_period.
module rgbw_led_drive_controller
    import rgbw_pkg::*;
#(
    parameter int MIRED_TABLE_DEPTH = 1024
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output      logic              o_in_ready,
    input  wire t_req              i_in_data,
    output      logic              o_out_valid,
    input  wire logic              i_out_ready,
    output      t_rsp              o_out_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output      logic [31:0]       prdata,
    output      logic              pready
);

    localparam int AW = $clog2(MIRED_TABLE_DEPTH);

    t_cfg cfg;

    // pipeline control
    logic    r_s1_valid;
    t_req    r_s1;
    logic    r_out_valid;
    t_rsp    r_out;
    logic    adv;
    logic    in_accept;
    logic [AW-1:0] rom_addr;
    t_rgb    rom_rgb;

    // stored settings
    logic        r_power,  n_power;
    logic [7:0]  r_bright, n_bright;
    logic [7:0]  r_red,    n_red;
    logic [7:0]  r_green,  n_green;
    logic [7:0]  r_blue,   n_blue;
    logic [7:0]  r_white,  n_white;
    logic [9:0]  r_mired,  n_mired;
    logic        r_effect, n_effect;
    logic [7:0]  r_hue,    n_hue;
    logic [31:0] r_tick,   n_tick;
    logic [7:0]  r_duty_r, n_duty_r;
    logic [7:0]  r_duty_g, n_duty_g;
    logic [7:0]  r_duty_b, n_duty_b;
    logic [7:0]  r_duty_w, n_duty_w;

    logic        acc;
    logic        do_refresh;
    logic        do_zero;
    logic [31:0] tick_inc;
    logic [7:0]  hue_off;
    logic [7:0]  hue_x3;
    t_rgb        hue_rgb;
    logic [7:0]  dim_r;
    logic [7:0]  dim_g;
    logic [7:0]  dim_b;

    rgbw_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign adv        = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || adv;
    assign in_accept  = i_in_valid && o_in_ready;

    assign rom_addr = (32'(i_in_data.mired_in) < 32'(MIRED_TABLE_DEPTH))
                    ? AW'(i_in_data.mired_in) : AW'(MIRED_TABLE_DEPTH - 1);

    rgbw_ct_rom #(
        .DEPTH (MIRED_TABLE_DEPTH)
    ) u_rom (
        .i_clk     (i_clk),
        .i_rd_en   (in_accept),
        .i_rd_addr (rom_addr),
        .o_rd_data (rom_rgb)
    );

    // rainbow color of the current hue
    always_comb begin
        if (r_hue < HUE_SEG1)      hue_off = r_hue;
        else if (r_hue < HUE_SEG2) hue_off = r_hue - HUE_SEG1;
        else                       hue_off = r_hue - HUE_SEG2;
        hue_x3 = 8'(10'(hue_off) * 10'd3);
        if (r_hue < HUE_SEG1) begin
            hue_rgb = '{red: hue_x3, green: 8'd255 - hue_x3, blue: 8'd0};
        end else if (r_hue < HUE_SEG2) begin
            hue_rgb = '{red: 8'd255 - hue_x3, green: 8'd0, blue: hue_x3};
        end else begin
            hue_rgb = '{red: 8'd0, green: hue_x3, blue: 8'd255 - hue_x3};
        end
    end

    assign tick_inc = (r_tick == '1) ? r_tick : r_tick + 32'd1;

    // command evaluation
    always_comb begin
        n_power    = r_power;
        n_bright   = r_bright;
        n_red      = r_red;
        n_green    = r_green;
        n_blue     = r_blue;
        n_white    = r_white;
        n_mired    = r_mired;
        n_effect   = r_effect;
        n_hue      = r_hue;
        n_tick     = r_tick;
        acc        = 1'b0;
        do_refresh = 1'b0;
        do_zero    = 1'b0;
        case (r_s1.req_type)
            REQ_POWER: begin
                if (r_s1.power_on != r_power) begin
                    acc        = 1'b1;
                    n_power    = r_s1.power_on;
                    do_refresh = r_s1.power_on;
                    do_zero    = !r_s1.power_on;
                end
            end
            REQ_BRIGHT: begin
                if (r_s1.level != r_bright) begin
                    acc        = 1'b1;
                    n_bright   = r_s1.level;
                    if (r_white != 8'd0) n_white = r_s1.level;
                    do_refresh = 1'b1;
                end
            end
            REQ_RGB: begin
                acc        = 1'b1;
                n_red      = r_s1.red_in;
                n_green    = r_s1.green_in;
                n_blue     = r_s1.blue_in;
                n_white    = 8'd0;
                do_refresh = 1'b1;
            end
            REQ_WHITE: begin
                if (r_s1.level != r_white) begin
                    acc        = 1'b1;
                    n_white    = r_s1.level;
                    n_bright   = r_s1.level;
                    n_red      = 8'd0;
                    n_green    = 8'd0;
                    n_blue     = 8'd0;
                    do_refresh = 1'b1;
                end
            end
            REQ_CT: begin
                if (r_s1.mired_in >= cfg.mired_min && r_s1.mired_in <= cfg.mired_max
                        && r_s1.mired_in != r_mired) begin
                    acc        = 1'b1;
                    n_mired    = r_s1.mired_in;
                    n_red      = rom_rgb.red;
                    n_green    = rom_rgb.green;
                    n_blue     = rom_rgb.blue;
                    n_white    = 8'd0;
                    do_refresh = 1'b1;
                end
            end
            REQ_EFFECT: begin
                acc      = 1'b1;
                n_effect = r_s1.effect_code;
            end
            REQ_TICK: begin
                n_tick = tick_inc;
                if (r_effect && tick_inc > cfg.rainbow_period) begin
                    acc        = 1'b1;
                    n_tick     = 32'd0;
                    n_red      = hue_rgb.red;
                    n_green    = hue_rgb.green;
                    n_blue     = hue_rgb.blue;
                    n_white    = 8'd0;
                    n_hue      = r_hue + 8'd1;
                    do_refresh = 1'b1;
                end
            end
            default: ;
        endcase
    end

    rgbw_dim u_dim_r (.i_color(n_red),   .i_bright(n_bright), .o_duty(dim_r));
    rgbw_dim u_dim_g (.i_color(n_green), .i_bright(n_bright), .o_duty(dim_g));
    rgbw_dim u_dim_b (.i_color(n_blue),  .i_bright(n_bright), .o_duty(dim_b));

    always_comb begin
        n_duty_r = r_duty_r;
        n_duty_g = r_duty_g;
        n_duty_b = r_duty_b;
        n_duty_w = r_duty_w;
        if (do_zero) begin
            n_duty_r = 8'd0;
            n_duty_g = 8'd0;
            n_duty_b = 8'd0;
            n_duty_w = 8'd0;
        end else if (do_refresh) begin
            n_duty_r = dim_r;
            n_duty_g = dim_g;
            n_duty_b = dim_b;
            n_duty_w = n_white;
        end
    end

    // control and settings
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_power     <= 1'b0;
            r_bright    <= 8'd255;
            r_red       <= 8'd0;
            r_green     <= 8'd0;
            r_blue      <= 8'd0;
            r_white     <= 8'd255;
            r_mired     <= 10'd0;
            r_effect    <= 1'b0;
            r_hue       <= 8'd0;
            r_tick      <= 32'd0;
            r_duty_r    <= 8'd0;
            r_duty_g    <= 8'd0;
            r_duty_b    <= 8'd0;
            r_duty_w    <= 8'd0;
        end else begin
            if (in_accept)  r_s1_valid <= 1'b1;
            else if (adv)   r_s1_valid <= 1'b0;

            if (adv)              r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;

            if (adv) begin
                r_power  <= n_power;
                r_bright <= n_bright;
                r_red    <= n_red;
                r_green  <= n_green;
                r_blue   <= n_blue;
                r_white  <= n_white;
                r_mired  <= n_mired;
                r_effect <= n_effect;
                r_hue    <= n_hue;
                r_tick   <= n_tick;
                r_duty_r <= n_duty_r;
                r_duty_g <= n_duty_g;
                r_duty_b <= n_duty_b;
                r_duty_w <= n_duty_w;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1 <= i_in_data;
        end
        if (adv) begin
            r_out.accepted       <= acc;
            r_out.duty_red       <= n_duty_r;
            r_out.duty_green     <= n_duty_g;
            r_out.duty_blue      <= n_duty_b;
            r_out.duty_white     <= n_duty_w;
            r_out.power_now      <= n_power;
            r_out.brightness_now <= n_bright;
            r_out.red_now        <= n_red;
            r_out.green_now      <= n_green;
            r_out.blue_now       <= n_blue;
            r_out.white_now      <= n_white;
            r_out.mired_now      <= n_mired;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---- assertions
    a_rgb_cmd_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && (r_s1.req_type == REQ_RGB)
        |=> o_out_valid && o_out_data.accepted && (o_out_data.white_now == 8'd0))
        else $error("rgb command did not produce an accepted result with white cleared");

    a_settings_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_power) && $stable(r_bright) && $stable(r_tick)
                 && $stable(r_duty_w))
        else $error("stored settings changed without a transaction in flight");

    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input accepted while both pipeline stages are stalled");

    a_power_off_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && (r_s1.req_type == REQ_POWER) && !r_s1.power_on && r_power
        |=> (o_out_data.duty_red == 8'd0) && (o_out_data.duty_white == 8'd0)
            && !o_out_data.power_now)
        else $error("power off left a nonzero duty");

endmodule

`default_nettype wire

@@ dv/rgbw_led_drive_controller_tb.sv @@
// Self-checking testbench for rgbw_led_drive_controller: directed and random command streams
// against a cycle-free predictor of the light state, with random idling on both channels.
// Depends on rgbw_pkg (request/response structs, request codes, register indexes) and the RTL.
module rgbw_led_drive_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rgbw_pkg::*;

    localparam logic [2:0] REQ_UNDEF   = 3'd7;
    localparam int         CT_DEPTH    = 1024;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         FX_FRAC     = 30;
    localparam logic [63:0] FX_ONE     = 64'd1 << FX_FRAC;
    localparam logic [63:0] SCALE_COEF = 64'd10000000;
    localparam logic [63:0] SCALE_EXPO = 64'd10000000000;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    t_req        i_in_data   = '0;
    logic        i_out_ready = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0] pwdata      = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    t_rsp        o_out_data;
    logic [31:0] prdata;
    logic        pready;

    rgbw_led_drive_controller dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // predicted light state and register copies
    logic        st_power  = 1'b0;
    logic [7:0]  st_bright = 8'd255;
    logic [7:0]  st_red    = 8'd0;
    logic [7:0]  st_green  = 8'd0;
    logic [7:0]  st_blue   = 8'd0;
    logic [7:0]  st_white  = 8'd255;
    logic [9:0]  st_mired  = 10'd0;
    logic        st_effect = 1'b0;
    logic [7:0]  st_hue    = 8'd0;
    logic [31:0] st_ticks  = 32'd0;
    logic [7:0]  st_duty [4] = '{8'd0, 8'd0, 8'd0, 8'd0};
    logic [9:0]  cfg_mired_lo   = MIRED_MIN_RST;
    logic [9:0]  cfg_mired_hi   = MIRED_MAX_RST;
    logic [31:0] cfg_hue_period = RB_PERIOD_RST;

    t_rgb ct_table [CT_DEPTH];
    t_rsp light_status_q [$];

    int  mismatch_cnt  = 0;
    int  cycle_cnt     = 0;
    int  stall_request = 0;
    int  stall_left    = 0;
    bit  tx_idle_on    = 1'b1;
    bit  rx_idle_on    = 1'b1;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ---- color temperature table, Q30 fixed point

    function automatic logic [63:0] fx_atanh2(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] z;
        logic [63:0] zz;
        logic [63:0] s;
        logic [63:0] p;
        z  = (num << FX_FRAC) / den;
        zz = (z * z) >> FX_FRAC;
        s  = z;
        p  = z;
        // once a term reaches zero every later one is zero too
        for (int n = 3; n <= 61; n += 2) begin
            p = (p * zz) >> FX_FRAC;
            s = s + p / 64'(n);
        end
        return 2 * s;
    endfunction

    function automatic logic [63:0] fx_ln(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] pow2;
        int          k;
        x = (x_in < 64'd1) ? 64'd1 : x_in;
        k = 0;
        while ((x >> (k + 1)) != 0) k++;
        pow2 = 64'd1 << k;
        return 64'(k) * fx_atanh2(64'd1, 64'd3) + fx_atanh2(x - pow2, x + pow2);
    endfunction

    function automatic logic [63:0] fx_exp_neg(input logic [63:0] t_in);
        logic [63:0] t;
        logic [63:0] acc;
        logic [63:0] term;
        t    = (t_in >= FX_ONE) ? FX_ONE - 64'd1 : t_in;
        acc  = FX_ONE;
        term = FX_ONE;
        for (int i = 1; i <= 24; i++) begin
            term = ((term * t) >> FX_FRAC) / 64'(i);
            if (i % 2 == 1) acc = (term > acc) ? 64'd0 : acc - term;
            else            acc = acc + term;
        end
        return acc;
    endfunction

    function automatic logic [7:0] clip8(input logic [63:0] v);
        return (v > 64'd255) ? 8'd255 : v[7:0];
    endfunction

    function automatic logic [7:0] power_curve(input logic [63:0] x, input logic [63:0] coef,
                                               input logic [63:0] expo);
        logic [63:0] t;
        logic [63:0] prod;
        t    = (expo * fx_ln(x)) / SCALE_EXPO;
        prod = coef * fx_exp_neg(t);
        return clip8((prod >> FX_FRAC) / SCALE_COEF);
    endfunction

    function automatic logic [7:0] log_curve(input logic [63:0] x, input logic [63:0] a,
                                             input logic [63:0] b);
        logic [63:0] p;
        logic [63:0] bq;
        p  = a * fx_ln(x);
        bq = b << FX_FRAC;
        if (p <= bq) return 8'd0;
        return clip8(((p - bq) >> FX_FRAC) / SCALE_COEF);
    endfunction

    function automatic t_rgb mired_color(input int unsigned m);
        logic [63:0] kel;
        logic [63:0] kk;
        t_rgb        c;
        kel = (m == 0) ? 64'd40000 : 64'd1000000 / 64'(m);
        if (kel < 64'd1000)  kel = 64'd1000;
        if (kel > 64'd40000) kel = 64'd40000;
        kk = kel / 64'd100;
        c.red   = (kk <= 64'd66) ? 8'd255
                                 : power_curve(kk - 64'd60, 64'd3296987274, 64'd1332047592);
        c.green = (kk <= 64'd66) ? log_curve(kk, 64'd994708025, 64'd1611195681)
                                 : power_curve(kk - 64'd60, 64'd2881221695, 64'd755148492);
        if (kk >= 64'd66)      c.blue = 8'd255;
        else if (kk <= 64'd19) c.blue = 8'd0;
        else c.blue = log_curve(kk - 64'd10, 64'd1385177312, 64'd3050447927);
        return c;
    endfunction

    // ---- light state predictor

    task automatic redo_duties();
        st_duty[0] = 8'((16'(st_red)   * 16'(st_bright)) / 16'd255);
        st_duty[1] = 8'((16'(st_green) * 16'(st_bright)) / 16'd255);
        st_duty[2] = 8'((16'(st_blue)  * 16'(st_bright)) / 16'd255);
        st_duty[3] = st_white;
    endtask

    task automatic load_rgb(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        st_red   = r;
        st_green = g;
        st_blue  = b;
        st_white = 8'd0;
        redo_duties();
    endtask

    task automatic advance_light(input t_req r, output t_rsp o);
        logic       acc;
        logic [7:0] h;
        t_rgb       c;
        acc = 1'b0;
        case (r.req_type)
            REQ_POWER: begin
                if (r.power_on != st_power) begin
                    acc = 1'b1;
                    st_power = r.power_on;
                    if (st_power) redo_duties();
                    else st_duty = '{8'd0, 8'd0, 8'd0, 8'd0};
                end
            end
            REQ_BRIGHT: begin
                if (r.level != st_bright) begin
                    acc = 1'b1;
                    st_bright = r.level;
                    if (st_white != 8'd0) st_white = r.level;
                    redo_duties();
                end
            end
            REQ_RGB: begin
                acc = 1'b1;
                load_rgb(r.red_in, r.green_in, r.blue_in);
            end
            REQ_WHITE: begin
                if (r.level != st_white) begin
                    acc = 1'b1;
                    st_white  = r.level;
                    st_bright = r.level;
                    st_red    = 8'd0;
                    st_green  = 8'd0;
                    st_blue   = 8'd0;
                    redo_duties();
                end
            end
            REQ_CT: begin
                if (r.mired_in >= cfg_mired_lo && r.mired_in <= cfg_mired_hi &&
                        r.mired_in != st_mired) begin
                    acc = 1'b1;
                    st_mired = r.mired_in;
                    c = ct_table[(int'(r.mired_in) < CT_DEPTH) ? int'(r.mired_in) : CT_DEPTH - 1];
                    load_rgb(c.red, c.green, c.blue);
                end
            end
            REQ_EFFECT: begin
                acc = 1'b1;
                st_effect = r.effect_code;
            end
            REQ_TICK: begin
                if (st_ticks != '1) st_ticks = st_ticks + 32'd1;
                if (st_effect && st_ticks > cfg_hue_period) begin
                    acc = 1'b1;
                    st_ticks = 32'd0;
                    h = st_hue;
                    if (h < HUE_SEG1) begin
                        load_rgb(8'(3 * h), 8'(255 - 3 * h), 8'd0);
                    end else if (h < HUE_SEG2) begin
                        h = h - HUE_SEG1;
                        load_rgb(8'(255 - 3 * h), 8'd0, 8'(3 * h));
                    end else begin
                        h = h - HUE_SEG2;
                        load_rgb(8'd0, 8'(3 * h), 8'(255 - 3 * h));
                    end
                    st_hue = st_hue + 8'd1;
                end
            end
            default: ;
        endcase
        o.accepted       = acc;
        o.duty_red       = st_duty[0];
        o.duty_green     = st_duty[1];
        o.duty_blue      = st_duty[2];
        o.duty_white     = st_duty[3];
        o.power_now      = st_power;
        o.brightness_now = st_bright;
        o.red_now        = st_red;
        o.green_now      = st_green;
        o.blue_now       = st_blue;
        o.white_now      = st_white;
        o.mired_now      = st_mired;
    endtask

    // ---- stimulus helpers

    function automatic t_req mk_req(input logic [2:0] req, input logic pw, input logic [7:0] lvl,
                                    input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                                    input logic [9:0] mir, input logic eff);
        t_req q;
        q.req_type    = req;
        q.power_on    = pw;
        q.level       = lvl;
        q.red_in      = r;
        q.green_in    = g;
        q.blue_in     = b;
        q.mired_in    = mir;
        q.effect_code = eff;
        return q;
    endfunction

    // weighted command mix; repeats of stored values are aimed for to reach the reject paths
    function automatic t_req random_cmd();
        t_req q;
        int   pick;
        q.power_on    = 1'($urandom_range(1));
        q.level       = 8'($urandom_range(255));
        q.red_in      = 8'($urandom_range(255));
        q.green_in    = 8'($urandom_range(255));
        q.blue_in     = 8'($urandom_range(255));
        q.mired_in    = 10'($urandom_range(1023));
        q.effect_code = ($urandom_range(3) != 0);
        pick = $urandom_range(99);
        if (pick < 8) begin
            q.req_type = REQ_POWER;
            if ($urandom_range(2) == 0) q.power_on = st_power;
        end else if (pick < 22) begin
            q.req_type = REQ_BRIGHT;
            if ($urandom_range(3) == 0) q.level = st_bright;
        end else if (pick < 36) begin
            q.req_type = REQ_RGB;
        end else if (pick < 46) begin
            q.req_type = REQ_WHITE;
            if ($urandom_range(3) == 0) q.level = st_white;
        end else if (pick < 66) begin
            q.req_type = REQ_CT;
            if ($urandom_range(7) == 0) q.mired_in = st_mired;
            else if ($urandom_range(1) == 0 && cfg_mired_lo <= cfg_mired_hi)
                q.mired_in = 10'($urandom_range(cfg_mired_hi, cfg_mired_lo));
        end else if (pick < 72) begin
            q.req_type = REQ_EFFECT;
        end else if (pick < 97) begin
            q.req_type = REQ_TICK;
        end else begin
            q.req_type = REQ_UNDEF;
        end
        return q;
    endfunction

    task automatic send_req(input t_req q);
        int   gap;
        t_rsp want;
        gap = 0;
        if (tx_idle_on) begin
            while ($urandom_range(99) < 25) gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= q;
        do @(posedge i_clk); while (!o_in_ready);
        advance_light(q, want);
        light_status_q.push_back(want);
    endtask

    task automatic send_random(input int n);
        repeat (n) send_req(random_cmd());
    endtask

    // stop offering and wait for every outstanding transaction to come back
    task automatic settle();
        i_in_valid <= 1'b0;
        while (light_status_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_light(input logic [9:0] lo, input logic [9:0] hi,
                                 input logic [31:0] period);
        settle();
        repeat (4) @(posedge i_clk);
        apb_write(REG_MIRED_MIN, 32'(lo));
        cfg_mired_lo = lo;
        apb_write(REG_MIRED_MAX, 32'(hi));
        cfg_mired_hi = hi;
        apb_write(REG_RB_PERIOD, period);
        cfg_hue_period = period;
    endtask

    // ---- tests

    task automatic test_directed();
        send_req(mk_req(REQ_POWER,  1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 10'd0,    1'b0));
        send_req(mk_req(REQ_POWER,  1'b1, 8'hff, 8'hff, 8'hff, 8'hff, 10'd1023, 1'b1));
        send_req(mk_req(REQ_BRIGHT, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 10'd0,    1'b0));
        send_req(mk_req(REQ_BRIGHT, 1'b1, 8'h00, 8'hff, 8'hff, 8'hff, 10'd1023, 1'b1));
        send_req(mk_req(REQ_BRIGHT, 1'b0, 8'hff, 8'h00, 8'h00, 8'h00, 10'd0,    1'b0));
        send_req(mk_req(REQ_RGB,    1'b0, 8'h00, 8'hff, 8'hff, 8'hff, 10'd0,    1'b0));
        send_req(mk_req(REQ_RGB,    1'b1, 8'hff, 8'h00, 8'h00, 8'h00, 10'd1023, 1'b1));
        send_req(mk_req(REQ_RGB,    1'b0, 8'h00, 8'haa, 8'h55, 8'h01, 10'd0,    1'b0));
        send_req(mk_req(REQ_BRIGHT, 1'b0, 8'h80, 8'h00, 8'h00, 8'h00, 10'd0,    1'b0));
        send_req(mk_req(REQ_WHITE,  1'b0, 8'hff, 8'h00, 8'h00, 8'h00, 10'd0,    1'b0));
        send_req(mk_req(REQ_WHITE,  1'b0, 8'hff, 8'h00, 8'h00, 8'h00, 10'd0,    1'b0));
        send_req(mk_req(REQ_WHITE,  1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 10'd0,    1'b0));
        // color temperature: both limits, a repeat, just outside each, and mired 0
        send_req(mk_req(REQ_CT,     1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 10'd153,  1'b0));
        send_req(mk_req(REQ_CT,     1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 10'd153,  1'b0));
        send_req(mk_req(REQ_CT,     1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 10'd152,  1'b0));
        send_req(mk_req(REQ_CT,     1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 10'd500,  1'b0));
        send_req(mk_req(REQ_CT,     1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 10'd501,  1'b0));
        send_req(mk_req(REQ_CT,     1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 10'd0,    1'b0));
        send_req(mk_req(REQ_EFFECT, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 10'd0,    1'b1));
        send_req(mk_req(REQ_TICK,   1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 10'd0,    1'b0));
        send_req(mk_req(REQ_EFFECT, 1'b1, 8'hff, 8'hff, 8'hff, 8'hff, 10'd1023, 1'b0));
        send_req(mk_req(REQ_UNDEF,  1'b1, 8'hff, 8'hff, 8'hff, 8'hff, 10'd1023, 1'b1));
        send_req(mk_req(REQ_POWER,  1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 10'd0,    1'b0));
        // duties still rewritten while off
        send_req(mk_req(REQ_BRIGHT, 1'b0, 8'h40, 8'h00, 8'h00, 8'h00, 10'd0,    1'b0));
        send_req(mk_req(REQ_RGB,    1'b0, 8'h00, 8'h12, 8'hfe, 8'h77, 10'd0,    1'b0));
        send_req(mk_req(REQ_POWER,  1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 10'd0,    1'b0));
    endtask

    task automatic test_extreme_limits();
        t_req q;
        program_light(10'd1, 10'd1023, 32'd0);
        send_req(mk_req(REQ_CT, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 10'd0,    1'b0));
        send_req(mk_req(REQ_CT, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 10'd1,    1'b0));
        send_req(mk_req(REQ_CT, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 10'd1023, 1'b0));
        send_req(mk_req(REQ_CT, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 10'd1023, 1'b0));
        send_req(mk_req(REQ_EFFECT, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 10'd0, 1'b1));
        // zero period: every tick steps the hue, run past a full wrap
        repeat (270) begin
            q = random_cmd();
            q.req_type = REQ_TICK;
            send_req(q);
        end
        send_random(150);
    endtask

    task automatic test_crossed_limits();
        program_light(10'd700, 10'd200, 32'hffff_ffff);
        send_random(150);
    endtask

    task automatic test_equal_limits();
        program_light(10'd400, 10'd400, 32'd3);
        send_random(150);
    endtask

    task automatic test_random_mix();
        program_light(MIRED_MIN_RST, MIRED_MAX_RST, RB_PERIOD_RST);
        send_random(700);
    endtask

    task automatic test_output_stall();
        stall_request = 400;
        send_random(150);
    endtask

    task automatic test_drain_pause();
        send_random(60);
        settle();
        send_random(60);
    endtask

    task automatic test_no_idle();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_random(200);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // ---- result side

    always @(posedge i_clk) begin
        if (stall_request != 0) begin
            stall_left    = stall_request;
            stall_request = 0;
        end
        if (stall_left != 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (rx_idle_on) begin
            i_out_ready <= ($urandom_range(99) >= 25);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    function automatic string status_str(input t_rsp s);
        return $sformatf("acc=%0b duty=%h/%h/%h/%h pwr=%0b bri=%h rgb=%h/%h/%h w=%h mir=%0d",
                         s.accepted, s.duty_red, s.duty_green, s.duty_blue, s.duty_white,
                         s.power_now, s.brightness_now, s.red_now, s.green_now, s.blue_now,
                         s.white_now, s.mired_now);
    endfunction

    function automatic bit status_matches(input t_rsp a, input t_rsp b);
        return a.accepted === b.accepted && a.duty_red === b.duty_red &&
               a.duty_green === b.duty_green && a.duty_blue === b.duty_blue &&
               a.duty_white === b.duty_white && a.power_now === b.power_now &&
               a.brightness_now === b.brightness_now && a.red_now === b.red_now &&
               a.green_now === b.green_now && a.blue_now === b.blue_now &&
               a.white_now === b.white_now && a.mired_now === b.mired_now;
    endfunction

    always @(posedge i_clk) begin : check_status
        t_rsp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (light_status_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected transaction: %s", status_str(o_out_data));
            end else begin
                want = light_status_q.pop_front();
                if (!status_matches(want, o_out_data)) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("expected %s", status_str(want));
                        $display("actual   %s", status_str(o_out_data));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("rgbw_led_drive_controller: mismatch");
            $finish;
        end
    end

    initial begin
        for (int m = 0; m < CT_DEPTH; m++) ct_table[m] = mired_color(m);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_extreme_limits();
        test_crossed_limits();
        test_equal_limits();
        test_random_mix();
        test_output_stall();
        test_drain_pause();
        test_no_idle();
        settle();
        repeat (8) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("rgbw_led_drive_controller: match");
        end else begin
            $display("rgbw_led_drive_controller: mismatch");
        end
        $finish;
    end

endmodule

@@ rgbw_led_drive_controller.f @@
sv/rgbw_pkg.sv
sv/rgbw_ct_rom.sv
sv/rgbw_dim.sv
sv/rgbw_apb_regs.sv
sv/rgbw_led_drive_controller.sv
dv/rgbw_led_drive_controller_tb.sv
